@@ sv/cache_line_compress_size_select_defines.svh @@
// Assertion macros shared by the cache line size selector.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef CACHE_LINE_COMPRESS_SIZE_SELECT_DEFINES_SVH
`define CACHE_LINE_COMPRESS_SIZE_SELECT_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define CLCSS_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CLCSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CLCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clcss_pkg.sv @@
// Shared types and codes for the cache line compressed-size selector.
// No dependencies.
`default_nettype none

package clcss_pkg;

  localparam int unsigned SIZE_W = 7;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned ALG_W  = 2;
  localparam int unsigned NZ_W   = 5;

  localparam logic [ALG_W-1:0] ALG_BDI    = 2'd0;
  localparam logic [ALG_W-1:0] ALG_ZERO   = 2'd1;
  localparam logic [ALG_W-1:0] ALG_BDELTA = 2'd2;
  localparam logic [ALG_W-1:0] ALG_UNCOMP = 2'd3;

  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [SIZE_W-1:0] SIZE_RAW  = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_ZERO = 7'd1;

  // Per-line properties gathered before the size decision.
  typedef struct packed {
    logic            all_zero;
    logic            same_byte;
    logic            ok_b8;
    logic            ok_w16;
    logic            ok_w32;
    logic            same_w32;
    logic            a32_lt7;
    logic            a32_lt15;
    logic            a64_lt7;
    logic            a64_lt15;
    logic            a64_lt31;
    logic [NZ_W-1:0] nz_cnt;
  } line_flags_t;

  typedef struct packed {
    logic [ALG_W-1:0]  algorithm;
    logic [MODE_W-1:0] encoding_mode;
    logic [SIZE_W-1:0] compressed_size;
  } size_result_t;

endpackage

`default_nettype wire

@@ sv/clcss_if.sv @@
// Valid/ready channels for cache lines in and size results out.
// Depends on nothing; payload widths follow the block's fields.
`default_nettype none

interface clcss_line_if;
  logic        valid;
  logic        ready;
  logic [63:0] line_word_0;
  logic [63:0] line_word_1;
  logic [63:0] line_word_2;
  logic [63:0] line_word_3;
  logic [63:0] line_word_4;
  logic [63:0] line_word_5;
  logic [63:0] line_word_6;
  logic [63:0] line_word_7;

  modport source (
    output valid, line_word_0, line_word_1, line_word_2, line_word_3,
           line_word_4, line_word_5, line_word_6, line_word_7,
    input  ready
  );
  modport sink (
    input  valid, line_word_0, line_word_1, line_word_2, line_word_3,
           line_word_4, line_word_5, line_word_6, line_word_7,
    output ready
  );
endinterface

interface clcss_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] algorithm;
  logic [2:0] encoding_mode;
  logic [6:0] compressed_size;

  modport source (output valid, algorithm, encoding_mode, compressed_size, input ready);
  modport sink   (input valid, algorithm, encoding_mode, compressed_size, output ready);
endinterface

`default_nettype wire

@@ sv/clcss_size_pick.sv @@
// Size decision: three engine minima and the cross-engine choice.
// Depends on clcss_pkg.
`default_nettype none

module clcss_size_pick (
  input  var clcss_pkg::line_flags_t  flags_i,
  output var clcss_pkg::size_result_t result_o
);

  // Zero engine modes
  localparam logic [2:0] ZM_ALL_ZERO = 3'd0;
  localparam logic [2:0] ZM_SPARSE   = 3'd1;
  localparam logic [2:0] ZM_NONE     = 3'd2;
  // Byte-delta engine modes
  localparam logic [2:0] BM_ALL_ZERO = 3'd0;
  localparam logic [2:0] BM_REPEAT   = 3'd1;
  localparam logic [2:0] BM_D8       = 3'd2;
  localparam logic [2:0] BM_D16      = 3'd3;
  localparam logic [2:0] BM_D32      = 3'd4;
  localparam logic [2:0] BM_NONE     = 3'd5;
  // BDI engine modes
  localparam logic [2:0] IM_ALL_ZERO = 3'd0;
  localparam logic [2:0] IM_REP32    = 3'd1;
  localparam logic [2:0] IM_B4D1     = 3'd2;
  localparam logic [2:0] IM_B4D2     = 3'd3;
  localparam logic [2:0] IM_B8D1     = 3'd4;
  localparam logic [2:0] IM_B8D2     = 3'd5;
  localparam logic [2:0] IM_B8D4     = 3'd6;
  localparam logic [2:0] IM_NONE     = 3'd7;

  localparam logic [6:0] SZ_REPEAT = 7'd2;
  localparam logic [6:0] SZ_SPARSE = 7'd3;
  localparam logic [6:0] SZ_REP32  = 7'd4;
  localparam logic [6:0] SZ_B8D1   = 7'd16;
  localparam logic [6:0] SZ_B4D1   = 7'd20;
  localparam logic [6:0] SZ_B8D2   = 7'd24;
  localparam logic [6:0] SZ_D8     = 7'd34;
  localparam logic [6:0] SZ_D32    = 7'd35;
  localparam logic [6:0] SZ_B4D2   = 7'd36;
  localparam logic [6:0] SZ_B8D4   = 7'd40;
  localparam logic [4:0] NZ_MAX    = 5'd8;

  logic [2:0] zm, bm, im;
  logic [6:0] zs, bs, is_sz;

  always_comb begin
    priority if (flags_i.all_zero) begin
      zm = ZM_ALL_ZERO; zs = clcss_pkg::SIZE_ZERO;
    end else if (flags_i.nz_cnt <= NZ_MAX) begin
      zm = ZM_SPARSE;   zs = SZ_SPARSE + {flags_i.nz_cnt, 2'b00};
    end else begin
      zm = ZM_NONE;     zs = clcss_pkg::SIZE_RAW;
    end
  end

  // Sizes rise down the chain; equal sizes keep the lower mode first.
  always_comb begin
    priority if (flags_i.all_zero) begin
      bm = BM_ALL_ZERO; bs = clcss_pkg::SIZE_ZERO;
    end else if (flags_i.same_byte) begin
      bm = BM_REPEAT;   bs = SZ_REPEAT;
    end else if (flags_i.ok_b8) begin
      bm = BM_D8;       bs = SZ_D8;
    end else if (flags_i.ok_w16) begin
      bm = BM_D16;      bs = SZ_D8;
    end else if (flags_i.ok_w32) begin
      bm = BM_D32;      bs = SZ_D32;
    end else begin
      bm = BM_NONE;     bs = clcss_pkg::SIZE_RAW;
    end
  end

  always_comb begin
    priority if (flags_i.all_zero) begin
      im = IM_ALL_ZERO; is_sz = clcss_pkg::SIZE_ZERO;
    end else if (flags_i.same_w32) begin
      im = IM_REP32;    is_sz = SZ_REP32;
    end else if (flags_i.a64_lt7) begin
      im = IM_B8D1;     is_sz = SZ_B8D1;
    end else if (flags_i.a32_lt7) begin
      im = IM_B4D1;     is_sz = SZ_B4D1;
    end else if (flags_i.a64_lt15) begin
      im = IM_B8D2;     is_sz = SZ_B8D2;
    end else if (flags_i.a32_lt15) begin
      im = IM_B4D2;     is_sz = SZ_B4D2;
    end else if (flags_i.a64_lt31) begin
      im = IM_B8D4;     is_sz = SZ_B8D4;
    end else begin
      im = IM_NONE;     is_sz = clcss_pkg::SIZE_RAW;
    end
  end

  // Strictly smaller wins across engines: zero, then byte-delta, then BDI; 64 or more is uncompressed.
  always_comb begin
    result_o.algorithm       = clcss_pkg::ALG_ZERO;
    result_o.encoding_mode   = zm;
    result_o.compressed_size = zs;
    if (bs < result_o.compressed_size) begin
      result_o.algorithm       = clcss_pkg::ALG_BDELTA;
      result_o.encoding_mode   = bm;
      result_o.compressed_size = bs;
    end
    if (is_sz < result_o.compressed_size) begin
      result_o.algorithm       = clcss_pkg::ALG_BDI;
      result_o.encoding_mode   = im;
      result_o.compressed_size = is_sz;
    end
    if (result_o.compressed_size >= clcss_pkg::SIZE_RAW) begin
      result_o.algorithm       = clcss_pkg::ALG_UNCOMP;
      result_o.encoding_mode   = clcss_pkg::MODE_NONE;
      result_o.compressed_size = clcss_pkg::SIZE_RAW;
    end
  end

endmodule

`default_nettype wire

@@ sv/cache_line_compress_size_select.sv @@
// An accepted line passes through stage 1 and stage 2 into stage 3, whose register
// drives the result; one line per cycle while the output is not stalled.
// Stage 1 registers element differences and equality flags, stage 2 the
// range flags and nonzero count, stage 3 the chosen algorithm, mode and size.
// Flow stops only under result back-pressure: a full stage holds only while every
// later stage is full too, and empty stages still fill.
// Reset (rst_ni low, asynchronous) empties all stages; payload is not reset.
// Depends on clcss_pkg, clcss_if, clcss_size_pick and the assertion defines header.
`default_nettype none
`include "cache_line_compress_size_select_defines.svh"

module cache_line_compress_size_select (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  clcss_line_if.sink          line_i,
  clcss_result_if.source      result_o
);

  logic [63:0] w64 [8];

  assign w64[0] = line_i.line_word_0;
  assign w64[1] = line_i.line_word_1;
  assign w64[2] = line_i.line_word_2;
  assign w64[3] = line_i.line_word_3;
  assign w64[4] = line_i.line_word_4;
  assign w64[5] = line_i.line_word_5;
  assign w64[6] = line_i.line_word_6;
  assign w64[7] = line_i.line_word_7;

  // Pipeline control
  logic v1_q, v2_q, v3_q;
  logic load1, load2, load3;

  assign load3        = !v3_q || result_o.ready;
  assign load2        = !v2_q || load3;
  assign load1        = !v1_q || load2;
  assign line_i.ready = load1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (load1) v1_q <= line_i.valid;
      if (load2) v2_q <= v1_q;
      if (load3) v3_q <= v2_q;
    end
  end

  // Stage 1: exact differences against the first element of each view
  logic [64:0] d64_d [8];
  logic [32:0] d32_d [16];
  logic [16:0] d16_d [32];
  logic [8:0]  d8_d  [64];
  logic [15:0] nz32_d, eq32_d;
  logic [63:0] eqb_d;

  logic [64:0] d64_q [8];
  logic [32:0] d32_q [16];
  logic [16:0] d16_q [32];
  logic [8:0]  d8_q  [64];
  logic [15:0] nz32_q, eq32_q;
  logic [63:0] eqb_q;

  always_comb begin
    logic [31:0] w32_0;
    logic [31:0] w32_i;
    logic [15:0] w16_0;
    logic [15:0] w16_i;
    logic [7:0]  b_0;
    logic [7:0]  b_i;
    w32_0 = w64[0][31:0];
    w16_0 = w64[0][15:0];
    b_0   = w64[0][7:0];
    for (int i = 0; i < 8; i++) begin
      d64_d[i] = {w64[i][63], w64[i]} - {w64[0][63], w64[0]};
    end
    for (int i = 0; i < 16; i++) begin
      w32_i     = w64[i / 2][32 * (i % 2) +: 32];
      d32_d[i]  = {w32_i[31], w32_i} - {w32_0[31], w32_0};
      nz32_d[i] = (w32_i != '0);
      eq32_d[i] = (w32_i == w32_0);
    end
    for (int i = 0; i < 32; i++) begin
      w16_i    = w64[i / 4][16 * (i % 4) +: 16];
      d16_d[i] = {1'b0, w16_i} - {1'b0, w16_0};
    end
    for (int i = 0; i < 64; i++) begin
      b_i      = w64[i / 8][8 * (i % 8) +: 8];
      d8_d[i]  = {1'b0, b_i} - {1'b0, b_0};
      eqb_d[i] = (b_i == b_0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      d64_q  <= d64_d;
      d32_q  <= d32_d;
      d16_q  <= d16_d;
      d8_q   <= d8_d;
      nz32_q <= nz32_d;
      eq32_q <= eq32_d;
      eqb_q  <= eqb_d;
    end
  end

  // Stage 2: range flags. A magnitude below 2^k means the upper bits are all
  // zero, or all one with a nonzero low part (which excludes -2^k).
  clcss_pkg::line_flags_t flags_d, flags_q;

  always_comb begin
    flags_d.all_zero  = ~|nz32_q;
    flags_d.same_byte = &eqb_q;
    flags_d.same_w32  = &eq32_q;
    flags_d.nz_cnt    = clcss_pkg::NZ_W'($countones(nz32_q));
    flags_d.ok_b8     = 1'b1;
    flags_d.ok_w16    = 1'b1;
    flags_d.ok_w32    = 1'b1;
    flags_d.a32_lt7   = 1'b1;
    flags_d.a32_lt15  = 1'b1;
    flags_d.a64_lt7   = 1'b1;
    flags_d.a64_lt15  = 1'b1;
    flags_d.a64_lt31  = 1'b1;
    for (int i = 0; i < 64; i++) begin
      if (!((d8_q[i][8:3] == '0) || (&d8_q[i][8:3]))) flags_d.ok_b8 = 1'b0;
    end
    for (int i = 0; i < 32; i++) begin
      if (!((d16_q[i][16:7] == '0) || (&d16_q[i][16:7]))) flags_d.ok_w16 = 1'b0;
    end
    for (int i = 0; i < 16; i++) begin
      if (!((d32_q[i][32:15] == '0) || (&d32_q[i][32:15]))) flags_d.ok_w32 = 1'b0;
      if (!((d32_q[i][32:7] == '0) || ((&d32_q[i][32:7]) && (d32_q[i][6:0] != '0))))
        flags_d.a32_lt7 = 1'b0;
      if (!((d32_q[i][32:15] == '0) || ((&d32_q[i][32:15]) && (d32_q[i][14:0] != '0))))
        flags_d.a32_lt15 = 1'b0;
    end
    for (int i = 0; i < 8; i++) begin
      if (!((d64_q[i][64:7] == '0) || ((&d64_q[i][64:7]) && (d64_q[i][6:0] != '0))))
        flags_d.a64_lt7 = 1'b0;
      if (!((d64_q[i][64:15] == '0) || ((&d64_q[i][64:15]) && (d64_q[i][14:0] != '0))))
        flags_d.a64_lt15 = 1'b0;
      if (!((d64_q[i][64:31] == '0) || ((&d64_q[i][64:31]) && (d64_q[i][30:0] != '0))))
        flags_d.a64_lt31 = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load2) flags_q <= flags_d;
  end

  // Stage 3: size decision into the output register
  clcss_pkg::size_result_t res_d, res_q;

  clcss_size_pick u_pick (
    .flags_i  (flags_q),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (load3) res_q <= res_d;
  end

  assign result_o.valid           = v3_q;
  assign result_o.algorithm       = res_q.algorithm;
  assign result_o.encoding_mode   = res_q.encoding_mode;
  assign result_o.compressed_size = res_q.compressed_size;

  `CLCSS_ASSERT_NEXT(a_accept_fills_s1, line_i.valid && line_i.ready, v1_q,
    "accepted line lost")
  `CLCSS_ASSERT_NEXT(a_s2_held_on_stall, v2_q && !load2, v2_q,
    "stalled stage 2 item dropped")
  `CLCSS_ASSERT_IMPL(a_raw_size, v3_q && (res_q.algorithm == clcss_pkg::ALG_UNCOMP),
    (res_q.compressed_size == clcss_pkg::SIZE_RAW) &&
    (res_q.encoding_mode == clcss_pkg::MODE_NONE),
    "uncompressed result with wrong size or mode")
  `CLCSS_ASSERT_IMPL(a_size_below_raw, v3_q && (res_q.algorithm != clcss_pkg::ALG_UNCOMP),
    res_q.compressed_size < clcss_pkg::SIZE_RAW,
    "compressed result not smaller than a raw line")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking bench for the cache line compressed-size selector.
// Predicts algorithm, mode and size per line; needs clcss_pkg, clcss_if and the RTL.
`timescale 1ns / 100ps

module tb_top;

  typedef logic [511:0] line_t;

  localparam int RANDOM_LINES = 1130;
  localparam int HOLD_OFF_AT  = 300;
  localparam int HOLD_OFF_LEN = 250;
  localparam int REPORT_MAX   = 10;

  // Modes of each engine, lowest first.
  localparam int ZM_ZERO = 0, ZM_SPARSE = 1, ZM_NONE = 2, ZM_COUNT = 3;
  localparam int BM_ZERO = 0, BM_SAME = 1, BM_B8 = 2, BM_W16 = 3, BM_W32 = 4, BM_NONE = 5;
  localparam int BM_COUNT = 6;
  localparam int IM_ZERO = 0, IM_REP32 = 1, IM_B32D8 = 2, IM_B32D16 = 3;
  localparam int IM_B64D8 = 4, IM_B64D16 = 5, IM_B64D32 = 6, IM_NONE = 7, IM_COUNT = 8;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  line_t tx_line = '0;
  logic  tx_valid = 1'b0;
  logic  rx_ready = 1'b0;

  clcss_line_if   line_if ();
  clcss_result_if res_if ();

  assign line_if.valid       = tx_valid;
  assign line_if.line_word_0 = tx_line[63:0];
  assign line_if.line_word_1 = tx_line[127:64];
  assign line_if.line_word_2 = tx_line[191:128];
  assign line_if.line_word_3 = tx_line[255:192];
  assign line_if.line_word_4 = tx_line[319:256];
  assign line_if.line_word_5 = tx_line[383:320];
  assign line_if.line_word_6 = tx_line[447:384];
  assign line_if.line_word_7 = tx_line[511:448];
  assign res_if.ready        = rx_ready;

  cache_line_compress_size_select u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .line_i   (line_if),
    .result_o (res_if)
  );

  line_t                   pending_q[$];
  clcss_pkg::size_result_t expected_q[$];
  int                      lines_sent = 0;
  int                      lines_total = 0;
  int                      results_seen = 0;
  int                      fail_count = 0;
  int                      alg_seen[4] = '{default: 0};
  int                      gap_left = 0;
  int                      stall_left = 0;
  int                      hold_off_left = 0;
  bit                      hold_off_done = 1'b0;
  bit                      tx_calm = 1'b0;
  bit                      rx_calm = 1'b0;

  // ---------------------------------------------------------------- predictor

  // Smallest size wins; ties go to the lower mode.
  function automatic void pick_smallest(input int sz[8], input int n,
                                        output int mode, output int size);
    mode = n - 1;
    size = 64;
    for (int m = n - 1; m >= 0; m--) begin
      if (sz[m] <= size) begin
        size = sz[m];
        mode = m;
      end
    end
  endfunction

  function automatic clcss_pkg::size_result_t predict_size(line_t ln);
    clcss_pkg::size_result_t res;
    bit all_zero, same_byte, ok_b8, ok_w16, ok_w32, same_w32;
    int nz_words, d, zm, zsz, bm, bsz, im, isz;
    longint d32, max32;
    logic signed [64:0] x0, xi, d64;
    logic [64:0] max64;
    int zero_sz[8], bd_sz[8], bdi_sz[8];
    all_zero  = (ln == '0);
    same_byte = 1'b1;
    ok_b8     = 1'b1;
    ok_w16    = 1'b1;
    ok_w32    = 1'b1;
    same_w32  = 1'b1;
    nz_words  = 0;
    max32     = 0;
    max64     = '0;
    for (int i = 0; i < 64; i++) begin
      d = int'(ln[8*i +: 8]) - int'(ln[7:0]);
      if (ln[8*i +: 8] != ln[7:0]) same_byte = 1'b0;
      if (d < -8 || d >= 8) ok_b8 = 1'b0;
    end
    for (int i = 0; i < 32; i++) begin
      d = int'(ln[16*i +: 16]) - int'(ln[15:0]);
      if (d < -128 || d >= 128) ok_w16 = 1'b0;
    end
    for (int i = 0; i < 16; i++) begin
      d32 = longint'($signed(ln[32*i +: 32])) - longint'($signed(ln[31:0]));
      if (ln[32*i +: 32] != 32'd0) nz_words++;
      if (ln[32*i +: 32] != ln[31:0]) same_w32 = 1'b0;
      if (d32 < -32768 || d32 >= 32768) ok_w32 = 1'b0;
      if (d32 < 0) d32 = -d32;
      if (d32 > max32) max32 = d32;
    end
    // 65-bit difference so that no pair of 64-bit words can wrap
    x0 = {ln[63], ln[63:0]};
    for (int i = 0; i < 8; i++) begin
      xi  = {ln[64*i+63], ln[64*i +: 64]};
      d64 = xi - x0;
      if (d64 < 0) d64 = -d64;
      if ($unsigned(d64) > max64) max64 = $unsigned(d64);
    end

    zero_sz = '{default: 64};
    zero_sz[ZM_ZERO]   = all_zero ? 1 : 64;
    zero_sz[ZM_SPARSE] = (nz_words <= 8) ? 3 + 4 * nz_words : 64;
    pick_smallest(zero_sz, ZM_COUNT, zm, zsz);

    bd_sz = '{default: 64};
    bd_sz[BM_ZERO] = all_zero ? 1 : 64;
    bd_sz[BM_SAME] = same_byte ? 2 : 64;
    bd_sz[BM_B8]   = ok_b8 ? 34 : 64;
    bd_sz[BM_W16]  = ok_w16 ? 34 : 64;
    bd_sz[BM_W32]  = ok_w32 ? 35 : 64;
    pick_smallest(bd_sz, BM_COUNT, bm, bsz);

    bdi_sz = '{default: 64};
    bdi_sz[IM_ZERO]   = all_zero ? 1 : 64;
    bdi_sz[IM_REP32]  = same_w32 ? 4 : 64;
    bdi_sz[IM_B32D8]  = (max32 < 128) ? 20 : 64;
    bdi_sz[IM_B32D16] = (max32 < 32768) ? 36 : 64;
    bdi_sz[IM_B64D8]  = (max64 < 65'd128) ? 16 : 64;
    bdi_sz[IM_B64D16] = (max64 < 65'd32768) ? 24 : 64;
    bdi_sz[IM_B64D32] = (max64 < 65'h8000_0000) ? 40 : 64;
    pick_smallest(bdi_sz, IM_COUNT, im, isz);

    res.algorithm       = clcss_pkg::ALG_ZERO;
    res.encoding_mode   = clcss_pkg::MODE_W'(zm);
    res.compressed_size = clcss_pkg::SIZE_W'(zsz);
    if (bsz < int'(res.compressed_size)) begin
      res.algorithm       = clcss_pkg::ALG_BDELTA;
      res.encoding_mode   = clcss_pkg::MODE_W'(bm);
      res.compressed_size = clcss_pkg::SIZE_W'(bsz);
    end
    if (isz < int'(res.compressed_size)) begin
      res.algorithm       = clcss_pkg::ALG_BDI;
      res.encoding_mode   = clcss_pkg::MODE_W'(im);
      res.compressed_size = clcss_pkg::SIZE_W'(isz);
    end
    if (res.compressed_size >= clcss_pkg::SIZE_RAW) begin
      res.algorithm       = clcss_pkg::ALG_UNCOMP;
      res.encoding_mode   = clcss_pkg::MODE_NONE;
      res.compressed_size = clcss_pkg::SIZE_RAW;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- line builders

  function automatic longint rand_between(longint lo, longint hi);
    longint unsigned span;
    span = longint'(hi - lo) + 1;
    return lo + longint'({$urandom(), $urandom()} % span);
  endfunction

  // Elements of w bits: base first, then base plus deltas in [lo, hi].
  // Both extremes always land somewhere in the line.
  function automatic line_t delta_line(int w, logic [63:0] base, longint lo, longint hi);
    line_t ln;
    logic [63:0] v;
    int n, pin_lo, pin_hi;
    ln     = '0;
    n      = 512 / w;
    pin_lo = $urandom_range(n - 1, 1);
    pin_hi = (pin_lo == n - 1) ? 1 : pin_lo + 1;
    for (int i = 0; i < n; i++) begin
      if (i == 0)           v = base;
      else if (i == pin_lo) v = base + lo;
      else if (i == pin_hi) v = base + hi;
      else                  v = base + rand_between(lo, hi);
      for (int b = 0; b < w; b++) ln[i*w + b] = v[b];
    end
    return ln;
  endfunction

  function automatic line_t sparse_line(int k);
    line_t ln;
    logic [15:0] used;
    int pos;
    logic [31:0] v;
    ln   = '0;
    used = '0;
    for (int j = 0; j < k; j++) begin
      do pos = $urandom_range(15); while (used[pos]);
      used[pos] = 1'b1;
      v = $urandom();
      if (v == 32'd0) v = 32'd1;
      ln[32*pos +: 32] = v;
    end
    return ln;
  endfunction

  function automatic line_t random_line();
    line_t ln;
    longint m;
    int pick;
    pick = $urandom_range(19);
    case (pick)
      0: ln = '0;
      1, 2: ln = sparse_line($urandom_range(10));
      3: ln = {64{8'($urandom())}};
      4, 5: begin
        if ($urandom_range(2) == 0) ln = delta_line(8, $urandom(), -9, 8);
        else                        ln = delta_line(8, $urandom(), -8, 7);
      end
      6, 7: begin
        if ($urandom_range(2) == 0) ln = delta_line(16, $urandom(), -129, 128);
        else                        ln = delta_line(16, $urandom(), -128, 127);
      end
      8: ln = delta_line(32, $urandom(), -32768, 32767);
      9: ln = delta_line(32, $urandom(), -127, 127);
      10: ln = {16{$urandom()}};
      11, 12, 13: begin
        case ($urandom_range(5))
          0: m = 127;
          1: m = 128;
          2: m = 32767;
          3: m = 32768;
          4: m = 64'h7FFF_FFFF;
          default: m = 64'h8000_0000;
        endcase
        ln = delta_line(64, {$urandom(), $urandom()}, -m, m);
      end
      14: begin
        case ($urandom_range(3))
          0: ln = delta_line(64, 64'h7FFF_FFFF_FFFF_FFFF, -64'h8000_0000, 64'h8000_0000);
          1: ln = delta_line(64, 64'h8000_0000_0000_0000, -64'h7FFF_FFFF, 64'h7FFF_FFFF);
          2: ln = delta_line(64, 64'hFFFF_FFFF_FFFF_FFFF, -200, 200);
          default: ln = delta_line(64, 64'd0, -40000, 40000);
        endcase
      end
      15, 16, 17: for (int i = 0; i < 16; i++) ln[32*i +: 32] = $urandom();
      18: begin
        for (int i = 0; i < 64; i++) begin
          case ($urandom_range(2))
            0: ln[8*i +: 8] = 8'h00;
            1: ln[8*i +: 8] = 8'hFF;
            default: ln[8*i +: 8] = 8'($urandom());
          endcase
        end
      end
      default: ln = delta_line(32, $urandom(), -32769, 32768);
    endcase
    // break a well-formed line now and then
    if ($urandom_range(7) == 0) ln[$urandom_range(511)] ^= 1'b1;
    return ln;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // ---------------------------------------------------------------- clock, reset, limit

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #6_000_000;
    $display("Timeout: %0d of %0d lines accepted, %0d results pending",
             lines_sent, lines_total, expected_q.size());
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- line driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (tx_valid && line_if.ready) begin
        expected_q.push_back(predict_size(tx_line));
        lines_sent <= lines_sent + 1;
      end
      if (!tx_valid || line_if.ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          tx_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          tx_line  <= pending_q.pop_front();
          tx_valid <= 1'b1;
          gap_left <= tx_calm ? 0 : pick_gap();
        end else begin
          tx_valid <= 1'b0;
        end
      end
      if ($urandom_range(127) == 0) tx_calm <= !tx_calm;
    end
  end

  // ---------------------------------------------------------------- long hold-off on results

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off_left <= 0;
    end else if (!hold_off_done && lines_sent >= HOLD_OFF_AT) begin
      hold_off_left <= HOLD_OFF_LEN;
      hold_off_done <= 1'b1;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk_i or negedge rst_ni) begin
    clcss_pkg::size_result_t got, want;
    if (!rst_ni) begin
      rx_ready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (res_if.valid && rx_ready) begin
        got.algorithm       = res_if.algorithm;
        got.encoding_mode   = res_if.encoding_mode;
        got.compressed_size = res_if.compressed_size;
        results_seen++;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%0t: unexpected result alg=%0d mode=%0d size=%0d", $realtime,
                     got.algorithm, got.encoding_mode, got.compressed_size);
        end else begin
          want = expected_q.pop_front();
          if (got.algorithm != want.algorithm || got.encoding_mode != want.encoding_mode ||
              got.compressed_size != want.compressed_size) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%0t: result %0d mismatch: alg %0d/%0d mode %0d/%0d size %0d/%0d (exp/act)",
                       $realtime, results_seen, want.algorithm, got.algorithm,
                       want.encoding_mode, got.encoding_mode,
                       want.compressed_size, got.compressed_size);
          end else begin
            alg_seen[got.algorithm]++;
          end
        end
      end
      if (hold_off_left != 0) begin
        rx_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        rx_ready   <= 1'b0;
      end else if (!rx_calm && $urandom_range(99) < 25) begin
        stall_left <= pick_gap();
        rx_ready   <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
      if ($urandom_range(127) == 0) rx_calm <= !rx_calm;
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    line_t ln;
    // extremes and one line per mode of every engine
    pending_q.push_back('0);
    pending_q.push_back('1);
    pending_q.push_back({64{8'h5A}});
    ln = '0;
    ln[511:480] = 32'h0000_0001;
    pending_q.push_back(ln);
    ln = '0;
    for (int i = 0; i < 16; i += 2) ln[32*i +: 32] = 32'hFFFF_FFFF - i;
    pending_q.push_back(ln);
    ln[32 +: 32] = 32'h8000_0000;
    pending_q.push_back(ln);
    pending_q.push_back({16{32'h8000_0000}});
    pending_q.push_back(delta_line(8, 64'h80, -8, 7));
    pending_q.push_back(delta_line(8, 64'h80, -8, 8));
    pending_q.push_back(delta_line(16, 64'h4000, -128, 127));
    pending_q.push_back(delta_line(16, 64'h4000, -129, 127));
    pending_q.push_back(delta_line(32, 64'd0, -32768, 32767));
    pending_q.push_back(delta_line(32, 64'd0, -32768, 32768));
    pending_q.push_back(delta_line(32, 64'h7FFF_FF00, -127, 127));
    pending_q.push_back(delta_line(64, 64'h0123_4567_89AB_CDEF, -127, 127));
    pending_q.push_back(delta_line(64, 64'h0123_4567_89AB_CDEF, -32767, 32767));
    pending_q.push_back(delta_line(64, 64'h0123_4567_89AB_CDEF, -64'h7FFF_FFFF, 64'h7FFF_FFFF));
    pending_q.push_back(delta_line(64, 64'h0123_4567_89AB_CDEF, -64'h8000_0000, 64'h8000_0000));
    pending_q.push_back(delta_line(64, 64'h7FFF_FFFF_FFFF_FFFF, -100, 0));
    pending_q.push_back(delta_line(64, 64'h8000_0000_0000_0000, 0, 100));
    // signed wrap against the base element must not look like a small delta
    pending_q.push_back(delta_line(64, 64'h7FFF_FFFF_FFFF_FFFF, 1, 1));
    pending_q.push_back(delta_line(32, 64'h7FFF_FFFF, 1, 1));
    pending_q.push_back({16{32'hA5C3_96E1}} ^ {8{64'h0000_0001_0000_0000}});
    for (int i = 0; i < RANDOM_LINES; i++) pending_q.push_back(random_line());
    lines_total = pending_q.size();

    while (lines_sent != lines_total) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("Lines checked: %0d (zero %0d, byte-delta %0d, BDI %0d, uncompressed %0d)",
             results_seen, alg_seen[clcss_pkg::ALG_ZERO], alg_seen[clcss_pkg::ALG_BDELTA],
             alg_seen[clcss_pkg::ALG_BDI], alg_seen[clcss_pkg::ALG_UNCOMP]);
    $display("Random gaps on both sides, one %0d-cycle result hold-off; %0d mismatches",
             HOLD_OFF_LEN, fail_count);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
